// File: rtl/core/arfp_pkg.sv
// Package for the ASCII range frame parser: character codes, frame lengths,
// parse mode enum, result struct and small decode helpers. No dependencies.
`default_nettype none

package arfp_pkg;

  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned SHORT_W = 7;
  localparam int unsigned LONG_W  = 10;
  localparam int unsigned N_SHORT = 4;
  localparam int unsigned N_LONG  = 2;

  localparam logic [POS_W-1:0] IR_LAST = 4'd11;
  localparam logic [POS_W-1:0] US_LAST = 4'd7;

  localparam logic KIND_IR = 1'b0;
  localparam logic KIND_US = 1'b1;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_IR   = 2'd1,
    MODE_US   = 2'd2
  } mode_e;

  typedef struct packed {
    logic                                 kind;
    logic [N_SHORT-1:0][SHORT_W-1:0]      ir_dist;
    logic [N_LONG-1:0][LONG_W-1:0]        us_dist;
  } result_t;

  typedef struct packed {
    logic       sep;
    logic [1:0] slot;
  } ir_slot_t;

  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [7:0] d;
    d = b - CHAR_ZERO;
    if (b < CHAR_ZERO || b > CHAR_NINE) begin
      return 4'd0;
    end
    return d[3:0];
  endfunction

  // Infrared body layout dd,dd,dd,dd.
  function automatic ir_slot_t ir_decode(input logic [POS_W-1:0] pos);
    ir_slot_t r;
    r = '{sep: 1'b0, slot: 2'd0};
    case (pos) inside
      4'd0, 4'd1:   r.slot = 2'd0;
      4'd3, 4'd4:   r.slot = 2'd1;
      4'd6, 4'd7:   r.slot = 2'd2;
      4'd9, 4'd10:  r.slot = 2'd3;
      default:      r.sep  = 1'b1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ascii_range_frame_parser_unit.sv
// Top level of the ASCII range frame parser: input byte register, parse core
// and result register. Depends on arfp_pkg, arfp_parse_core, arfp_out_reg.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  rx_byte_i
//   out      output     out_valid_o / out_ready_i frame_kind_o, ir_distance_*_o,
//                                                us_distance_*_o
//
// One byte per cycle sustained while the input is not stalled; a result
// is valid after its last byte passes the input then the result register.
// Reset clears the mode, position, pending and held distances to zero.
// The input register stalls only when a frame-ending byte would overwrite a
// result still waiting in the result register.
`default_nettype none

module ascii_range_frame_parser_unit import arfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            frame_kind_o,
  output logic [6:0]      ir_distance_1_o,
  output logic [6:0]      ir_distance_2_o,
  output logic [6:0]      ir_distance_3_o,
  output logic [6:0]      ir_distance_4_o,
  output logic [9:0]      us_distance_1_o,
  output logic [9:0]      us_distance_2_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       step;
  logic       emit;
  logic       out_busy;
  result_t    core_result;
  result_t    out_result;

  assign step       = in_valid_q & ~(emit & out_busy);
  assign in_ready_o = ~in_valid_q | step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  arfp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (byte_q),
    .emit_o   (emit),
    .result_o (core_result)
  );

  arfp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step & emit),
    .result_i (core_result),
    .busy_o   (out_busy),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign frame_kind_o    = out_result.kind;
  assign ir_distance_1_o = out_result.ir_dist[0];
  assign ir_distance_2_o = out_result.ir_dist[1];
  assign ir_distance_3_o = out_result.ir_dist[2];
  assign ir_distance_4_o = out_result.ir_dist[3];
  assign us_distance_1_o = out_result.us_dist[0];
  assign us_distance_2_o = out_result.us_dist[1];

endmodule

`default_nettype wire

// File: rtl/core/arfp_parse_core.sv
// Parse core: mode FSM, byte position, separator check, digit accumulation
// and held distances. Uses arfp_pkg.
`default_nettype none

module arfp_parse_core import arfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output result_t         result_o
);

  mode_e                         mode_q, mode_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic                          good_q, good_d;
  logic [N_SHORT-1:0][SHORT_W-1:0] pend_s_q, pend_s_d;
  logic [N_LONG-1:0][LONG_W-1:0]   pend_l_q, pend_l_d;
  logic [N_SHORT-1:0][SHORT_W-1:0] held_s_q, held_s_d;
  logic [N_LONG-1:0][LONG_W-1:0]   held_l_q, held_l_d;

  ir_slot_t    ir_dec;
  logic        us_sep;
  logic        sep_ok;
  logic        sep_want_dot;
  logic [3:0]  digit;
  logic        last;

  assign ir_dec = ir_decode(pos_q);
  assign us_sep = (pos_q[1:0] == 2'd3);
  assign digit  = digit_of(byte_i);
  assign last   = ((mode_q == MODE_IR) && (pos_q == IR_LAST)) ||
                  ((mode_q == MODE_US) && (pos_q == US_LAST));
  assign sep_want_dot = last;
  assign sep_ok = sep_want_dot ? (byte_i == CHAR_DOT) : (byte_i == CHAR_COMMA);

  // next mode
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q) inside
      MODE_IR, MODE_US: begin
        if (last) begin
          mode_d = MODE_HUNT;
        end
      end
      default: begin
        if (byte_i == CHAR_I) begin
          mode_d = MODE_IR;
        end else if (byte_i == CHAR_U) begin
          mode_d = MODE_US;
        end else begin
          mode_d = MODE_HUNT;
        end
      end
    endcase
  end

  // datapath
  always_comb begin
    pos_d    = pos_q;
    good_d   = good_q;
    pend_s_d = pend_s_q;
    pend_l_d = pend_l_q;
    held_s_d = held_s_q;
    held_l_d = held_l_q;
    emit_o   = 1'b0;
    unique case (mode_q)
      MODE_IR: begin
        if (ir_dec.sep) begin
          good_d = good_q & sep_ok;
        end else begin
          pend_s_d[ir_dec.slot] = SHORT_W'(pend_s_q[ir_dec.slot] * SHORT_W'(10)
                                  + SHORT_W'(digit));
        end
        pos_d = pos_q + POS_W'(1);
        if (last) begin
          if (good_d) begin
            held_s_d = pend_s_d;
            emit_o   = 1'b1;
          end
          pos_d    = '0;
          good_d   = 1'b1;
          pend_s_d = '0;
          pend_l_d = '0;
        end
      end
      MODE_US: begin
        if (us_sep) begin
          good_d = good_q & sep_ok;
        end else begin
          pend_l_d[pos_q[2]] = LONG_W'(pend_l_q[pos_q[2]] * LONG_W'(10)
                               + LONG_W'(digit));
        end
        pos_d = pos_q + POS_W'(1);
        if (last) begin
          if (good_d) begin
            held_l_d = pend_l_d;
            emit_o   = 1'b1;
          end
          pos_d    = '0;
          good_d   = 1'b1;
          pend_s_d = '0;
          pend_l_d = '0;
        end
      end
      default: begin
        pos_d    = '0;
        good_d   = 1'b1;
        pend_s_d = '0;
        pend_l_d = '0;
      end
    endcase
  end

  assign result_o.kind    = (mode_q == MODE_US) ? KIND_US : KIND_IR;
  assign result_o.ir_dist = held_s_d;
  assign result_o.us_dist = held_l_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HUNT;
      pos_q    <= '0;
      good_q   <= 1'b1;
      pend_s_q <= '0;
      pend_l_q <= '0;
      held_s_q <= '0;
      held_l_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      good_q   <= good_d;
      pend_s_q <= pend_s_d;
      pend_l_q <= pend_l_d;
      held_s_q <= held_s_d;
      held_l_q <= held_l_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arfp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Uses arfp_pkg for the result struct.
`default_nettype none

module arfp_out_reg import arfp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         busy_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign busy_o  = valid_q & ~ready_i;
  assign valid_o = valid_q;
  assign result_o = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire
